// ===== rtl/signed_integer_to_radix_ascii_assert.svh =====
// Assertion macros shared by the signed integer to radix text block.
`ifndef SIGNED_INTEGER_TO_RADIX_ASCII_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_ASCII_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on an explicit clock and active-low reset.
`define SIRTA_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check a property on the block clock and reset.
`define SIRTA_ASSERT(lbl, prop, msg) `SIRTA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define SIRTA_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define SIRTA_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== rtl/sirta_pkg.sv =====
// Types, constants and helper functions of the signed integer to radix text block.
`timescale 1ns / 1ps

package sirta_pkg;

  localparam int ValueBits     = 32;
  localparam int RadixW        = 8;
  localparam int CharW         = 8;
  localparam int MinRadix      = 2;
  localparam int MaxRadix      = 32;
  localparam int DigitW        = 5;
  localparam int RemW          = DigitW + 1;
  localparam int CntW          = $clog2(ValueBits + 1);
  localparam int AddrW         = $clog2(ValueBits);
  localparam int BitsPerCycle  = 8;
  localparam int StepsPerDigit = (ValueBits + BitsPerCycle - 1) / BitsPerCycle;
  localparam int PadW          = StepsPerDigit * BitsPerCycle;
  localparam int StepW         = (StepsPerDigit > 1) ? $clog2(StepsPerDigit) : 1;
  localparam int FifoDepth     = 2;
  localparam int DecimalBase   = 10;

  localparam logic [CharW-1:0] CharMinus   = 8'h2D;
  localparam logic [CharW-1:0] CharZero    = 8'h30;
  localparam logic [CharW-1:0] CharLetterA = 8'h41;

  typedef struct packed {
    logic signed [ValueBits-1:0] value;
    logic [RadixW-1:0]           radix;
  } sirta_in_t;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last;
    logic             bad_radix;
  } sirta_out_t;

  typedef struct packed {
    logic                 bad;
    logic                 neg;
    logic [RemW-1:0]      radix;
    logic [ValueBits-1:0] mag;
  } sirta_job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_READ,
    S_SEND,
    S_BAD
  } sirta_state_e;

  function automatic logic [CharW-1:0] glyph(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < DigitW'(DecimalBase)) begin
      c = CharZero + CharW'(d);
    end else begin
      c = CharLetterA + CharW'(d) - CharW'(DecimalBase);
    end
    return c;
  endfunction

endpackage

// ===== rtl/sirta_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sirta_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sirta_front.sv =====
// Front end: accept requests, check the radix and form the magnitude.
`timescale 1ns / 1ps

module sirta_front (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sirta_pkg::sirta_in_t  in_req_i,
  input  logic                  fifo_full_i,
  output logic                  push_o,
  output sirta_pkg::sirta_job_t job_o
);

  logic                           neg;
  logic [sirta_pkg::ValueBits-1:0] raw;

  assign raw = in_req_i.value;
  assign neg = raw[sirta_pkg::ValueBits-1];

  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  always_comb begin
    job_o.bad   = (in_req_i.radix < sirta_pkg::RadixW'(sirta_pkg::MinRadix)) ||
                  (in_req_i.radix > sirta_pkg::RadixW'(sirta_pkg::MaxRadix));
    job_o.neg   = neg;
    job_o.radix = in_req_i.radix[sirta_pkg::RemW-1:0];
    // Two's complement negate; the most negative value maps to its full magnitude.
    job_o.mag   = neg ? (~raw + 1'b1) : raw;
  end

endmodule

// ===== rtl/sirta_fifo.sv =====
// Two-entry queue between the front end and the conversion engine.
`timescale 1ns / 1ps

`include "signed_integer_to_radix_ascii_assert.svh"

module sirta_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sirta_pkg::sirta_job_t data_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  logic                  pop_i,
  output sirta_pkg::sirta_job_t data_o
);

  localparam int PtrW = (sirta_pkg::FifoDepth > 1) ? $clog2(sirta_pkg::FifoDepth) : 1;
  localparam int FillW = $clog2(sirta_pkg::FifoDepth + 1);

  sirta_pkg::sirta_job_t slot_q [sirta_pkg::FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == FillW'(sirta_pkg::FifoDepth));
  assign valid_o = (fill_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    if (p == PtrW'(sirta_pkg::FifoDepth - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    fill_d   = fill_q + FillW'(push_i) - FillW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  `SIRTA_ASSERT(a_fifo_no_overflow, !(push_i && full_o), "push into a full queue")
  `SIRTA_ASSERT(a_fifo_no_underflow, !(pop_i && !valid_o), "pop from an empty queue")
  `SIRTA_ASSERT(a_fifo_fill_bound, fill_q <= FillW'(sirta_pkg::FifoDepth), "queue fill out of range")

endmodule

// ===== rtl/sirta_back.sv =====
// Conversion engine: divide out digits, store them, then emit the text.
`timescale 1ns / 1ps

`include "signed_integer_to_radix_ascii_assert.svh"

module sirta_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  sirta_pkg::sirta_job_t job_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sirta_pkg::sirta_out_t out_req_o
);

  sirta_pkg::sirta_state_e state_q, state_d;

  logic                            neg_q, neg_d;
  logic [sirta_pkg::RemW-1:0]      radix_q, radix_d;
  logic [sirta_pkg::PadW-1:0]      div_q, div_d;
  logic [sirta_pkg::RemW-1:0]      rem_q, rem_d;
  logic [sirta_pkg::StepW-1:0]     step_q, step_d;
  logic [sirta_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic                            out_valid_q, out_valid_d;
  sirta_pkg::sirta_out_t           out_q, out_d;

  logic [sirta_pkg::PadW-1:0]      div_nx;
  logic [sirta_pkg::RemW-1:0]      rem_nx;
  logic                            last_step;
  logic                            quot_zero;
  logic                            can_load;
  logic                            send_last;

  logic                            ram_we, ram_re;
  logic [sirta_pkg::AddrW-1:0]     ram_waddr, ram_raddr;
  logic [sirta_pkg::DigitW-1:0]    ram_rdata;

  // Restoring division, several quotient bits per cycle; remainder stays narrow.
  always_comb begin
    rem_nx = rem_q;
    div_nx = div_q;
    for (int i = 0; i < sirta_pkg::BitsPerCycle; i++) begin
      rem_nx = {rem_nx[sirta_pkg::RemW-2:0], div_nx[sirta_pkg::PadW-1]};
      div_nx = {div_nx[sirta_pkg::PadW-2:0], 1'b0};
      if (rem_nx >= radix_q) begin
        rem_nx    = rem_nx - radix_q;
        div_nx[0] = 1'b1;
      end
    end
  end

  assign last_step = (step_q == sirta_pkg::StepW'(sirta_pkg::StepsPerDigit - 1));
  assign quot_zero = (div_nx == '0);
  assign can_load  = !out_valid_q || out_ready_i;
  assign send_last = (cnt_q == sirta_pkg::CntW'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sirta_pkg::S_IDLE: begin
        if (job_valid_i) begin
          state_d = job_i.bad ? sirta_pkg::S_BAD : sirta_pkg::S_DIV;
        end
      end
      sirta_pkg::S_DIV: begin
        if (last_step && quot_zero) begin
          state_d = neg_q ? sirta_pkg::S_SIGN : sirta_pkg::S_READ;
        end
      end
      sirta_pkg::S_SIGN: begin
        if (can_load) begin
          state_d = sirta_pkg::S_READ;
        end
      end
      sirta_pkg::S_READ: begin
        state_d = sirta_pkg::S_SEND;
      end
      sirta_pkg::S_SEND: begin
        if (can_load) begin
          state_d = send_last ? sirta_pkg::S_IDLE : sirta_pkg::S_READ;
        end
      end
      sirta_pkg::S_BAD: begin
        if (can_load) begin
          state_d = sirta_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sirta_pkg::S_IDLE;
      end
    endcase
  end

  // Control outputs and datapath updates.
  always_comb begin
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = cnt_q[sirta_pkg::AddrW-1:0];
    ram_raddr   = sirta_pkg::AddrW'(cnt_q - 1'b1);
    neg_d       = neg_q;
    radix_d     = radix_q;
    div_d       = div_q;
    rem_d       = rem_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      sirta_pkg::S_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          neg_d   = job_i.neg;
          radix_d = job_i.radix;
          div_d   = sirta_pkg::PadW'(job_i.mag);
          rem_d   = '0;
          step_d  = '0;
          cnt_d   = '0;
        end
      end
      sirta_pkg::S_DIV: begin
        div_d = div_nx;
        if (last_step) begin
          ram_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          rem_d  = '0;
          step_d = '0;
        end else begin
          rem_d  = rem_nx;
          step_d = step_q + 1'b1;
        end
      end
      sirta_pkg::S_SIGN: begin
        if (can_load) begin
          out_valid_d     = 1'b1;
          out_d.char_code = sirta_pkg::CharMinus;
          out_d.last      = 1'b0;
          out_d.bad_radix = 1'b0;
        end
      end
      sirta_pkg::S_READ: begin
        ram_re = 1'b1;
      end
      sirta_pkg::S_SEND: begin
        if (can_load) begin
          out_valid_d     = 1'b1;
          out_d.char_code = sirta_pkg::glyph(ram_rdata);
          out_d.last      = send_last;
          out_d.bad_radix = 1'b0;
          cnt_d           = cnt_q - 1'b1;
        end
      end
      sirta_pkg::S_BAD: begin
        if (can_load) begin
          out_valid_d     = 1'b1;
          out_d.char_code = '0;
          out_d.last      = 1'b1;
          out_d.bad_radix = 1'b1;
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sirta_pkg::S_IDLE;
      cnt_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    radix_q <= radix_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    out_q   <= out_d;
  end

  sirta_ram #(
    .Width (sirta_pkg::DigitW),
    .Depth (sirta_pkg::ValueBits)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rem_nx[sirta_pkg::DigitW-1:0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `SIRTA_ASSERT(a_rem_below_radix, (state_q == sirta_pkg::S_DIV) |-> (rem_q < radix_q), "partial remainder not below radix")
  `SIRTA_ASSERT(a_cnt_bound, cnt_q <= sirta_pkg::CntW'(sirta_pkg::ValueBits), "digit count beyond store depth")
  `SIRTA_ASSERT(a_emit_has_digits, ((state_q == sirta_pkg::S_READ) || (state_q == sirta_pkg::S_SEND)) |-> (cnt_q != '0), "emitting with no stored digit")
  `SIRTA_ASSERT(a_bad_shape, (out_valid_q && out_q.bad_radix) |-> (out_q.last && (out_q.char_code == '0)), "bad radix result malformed")

endmodule

// ===== rtl/signed_integer_to_radix_ascii.sv =====
// Top level of the signed integer to radix ASCII text converter.
`timescale 1ns / 1ps

// Usage:
//   in channel  : in_valid_i / in_ready_o carry one request (value, radix).
//   out channel : out_valid_o / out_ready_i carry one character per result,
//                 most significant digit first, a leading '-' for negative
//                 values, with last set on the final character.
//   A radix outside 2..32 yields a single result with char_code zero, last
//   and bad_radix set.
// Flow:
//   A request waits in a two-entry queue until the idle engine loads it.
//   Each digit is divided out by the shared divider, which retires 8
//   quotient bits per cycle; each character then takes a digit RAM read
//   and an output register load.
//   Requests are taken while the engine works, until the queue is full.
// Reset: clears the queue, the engine state and the output valid; the
//   digit RAM is not cleared, every entry is written before it is read.
// Stall: when out_ready_i is low the output register holds its character
//   and the engine waits to load the next one; the queue keeps taking requests until full.
module signed_integer_to_radix_ascii (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sirta_pkg::sirta_in_t  in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sirta_pkg::sirta_out_t out_req_o
);

  // Front end to queue.
  logic                  push;
  logic                  fifo_full;
  sirta_pkg::sirta_job_t job_in;

  // Queue to engine.
  logic                  job_valid;
  logic                  pop;
  sirta_pkg::sirta_job_t job_out;

  // Classify the request: radix check, sign and magnitude.
  sirta_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .job_o       (job_in)
  );

  // Hold classified requests so the front end need not wait on the divider until the queue is full.
  sirta_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (fifo_full),
    .valid_o (job_valid),
    .pop_i   (pop),
    .data_o  (job_out)
  );

  // Divide out the digits, then stream the characters through the output register.
  sirta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

// ===== tb/tb_signed_integer_to_radix_ascii.sv =====
// Testbench for the signed integer to radix ASCII text converter.
`timescale 1ns / 1ps

module tb_signed_integer_to_radix_ascii;
  import sirta_pkg::*;

  localparam int ClkPeriod    = 8;
  localparam int ResetCycles  = 5;
  // Cycles without any handshake before the run is declared hung. A radix 2
  // conversion has the most digits and the receiver may stall long stretches.
  localparam int IdleLimit    = 4000;
  // Quiet time after the last character so stray results still show up.
  localparam int SettleCycles = 250;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  sirta_in_t  in_req_i    = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  sirta_out_t out_req_o;

  // Requests waiting to be driven, and characters the block still owes us.
  sirta_in_t   pending_reqs[$];
  sirta_out_t  expected_chars[$];

  // Idle percentages of the sender (gap) and the receiver (stall).
  int          gap_pct       = 6;
  int          stall_pct     = 75;
  int unsigned reqs_queued   = 0;
  int unsigned reqs_accepted = 0;
  logic        req_taken     = 1'b0;
  int          error_count   = 0;
  int          idle_cycles   = 0;

  signed_integer_to_radix_ascii DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Map a digit value to its character: '0'..'9', then 'A'..'V'.
  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
    if (d < DecimalBase) begin
      return CharZero + CharW'(d);
    end
    return CharLetterA + CharW'(d) - CharW'(DecimalBase);
  endfunction

  // Compute the text of one request and append its characters to the
  // expected stream, sign first, most significant digit first.
  function automatic void predict_text(input sirta_in_t req);
    logic [ValueBits-1:0] mag;
    logic [ValueBits-1:0] base;
    logic [DigitW-1:0]    digits[ValueBits];
    int                   n;
    sirta_out_t           ch;
    n = 0;
    if (req.radix < MinRadix || req.radix > MaxRadix) begin
      ch.char_code = '0;
      ch.last      = 1'b1;
      ch.bad_radix = 1'b1;
      expected_chars.push_back(ch);
      return;
    end
    base = ValueBits'(req.radix);
    // Negate as unsigned so the most negative value yields 2^(N-1).
    mag  = req.value[ValueBits-1] ? ValueBits'(0) - req.value : req.value;
    do begin
      digits[n] = DigitW'(mag % base);
      n++;
      mag = mag / base;
    end while (mag != 0);
    if (req.value[ValueBits-1]) begin
      ch.char_code = CharMinus;
      ch.last      = 1'b0;
      ch.bad_radix = 1'b0;
      expected_chars.push_back(ch);
    end
    while (n > 0) begin
      n--;
      ch.char_code = digit_char(digits[n]);
      ch.last      = (n == 0);
      ch.bad_radix = 1'b0;
      expected_chars.push_back(ch);
    end
  endfunction

  task automatic queue_req(input logic [ValueBits-1:0] value, input logic [RadixW-1:0] radix);
    sirta_in_t req;
    req.value = value;
    req.radix = radix;
    pending_reqs.push_back(req);
    reqs_queued++;
  endtask

  // Pick a value that stresses the digit count: full range, small numbers,
  // shifted-down words, or powers of the radix just at and below a digit step.
  function automatic logic [ValueBits-1:0] random_value(input int unsigned radix);
    logic [ValueBits-1:0] v;
    logic [63:0]          p;
    int                   sel;
    sel = $urandom_range(3);
    case (sel)
      0: v = $urandom;
      1: v = $urandom_range(200) - 100;
      2: v = $urandom >> $urandom_range(ValueBits - 1);
      default: begin
        p = 1;
        repeat ($urandom_range(ValueBits - 1)) begin
          if (radix >= MinRadix && p * radix < 64'h8000_0000) p = p * radix;
        end
        v = p[ValueBits-1:0] - $urandom_range(1);
      end
    endcase
    if (sel >= 2 && $urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  // Mostly legal radices with random content; the rest is bad-radix noise.
  task automatic queue_random_req();
    int unsigned pick;
    int unsigned radix;
    pick = $urandom_range(99);
    if (pick < 6) begin
      radix = $urandom_range(1);
    end else if (pick < 12) begin
      radix = $urandom_range(255, MaxRadix + 1);
    end else begin
      radix = $urandom_range(MaxRadix, MinRadix);
    end
    queue_req(random_value(radix), RadixW'(radix));
  endtask

  // Set the idle mix, queue a batch of random requests, then hold the sender
  // back until every character of the batch has come out.
  task automatic run_phase(input int gap, input int stall, input int count);
    @(posedge clk_i);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (count) queue_random_req();
    do @(negedge clk_i); while (reqs_accepted != reqs_queued || expected_chars.size() != 0);
  endtask

  // Driver: change inputs on the falling edge only. Keep a request on the
  // bus until the last rising edge took it; then advance or drop valid.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
      if (!in_valid_i || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_req_i   <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: sample both channels on the rising edge. Check a character
  // before predicting a new request; a result never leaves the same cycle
  // its request arrives.
  always @(posedge clk_i) begin
    sirta_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character: char_code %h last %b bad_radix %b",
                 out_req_o.char_code, out_req_o.last, out_req_o.bad_radix);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_req_o.char_code !== want.char_code) begin
            $error("char_code: expected %h, actual %h", want.char_code, out_req_o.char_code);
            error_count++;
          end
          if (out_req_o.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_req_o.last);
            error_count++;
          end
          if (out_req_o.bad_radix !== want.bad_radix) begin
            $error("bad_radix: expected %b, actual %b", want.bad_radix, out_req_o.bad_radix);
            error_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_text(in_req_i);
        reqs_accepted++;
      end
    end
    req_taken <= rst_ni && in_valid_i && in_ready_o;
  end

  // Watchdog: end the run once no request and no character has moved
  // for IdleLimit cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL signed_integer_to_radix_ascii");
        $finish;
      end
    end
  end

  initial begin
    // Directed requests: zero, one, minus one, the signed extremes in the
    // smallest, decimal and largest radices, the top digit 'V', the first
    // letter, and every kind of bad radix (0, 1, just above 32, 255).
    queue_req(32'd0, 8'd10);
    queue_req(32'd0, 8'd2);
    queue_req(32'd1, 8'd2);
    queue_req(-32'sd1, 8'd2);
    queue_req(-32'sd1, 8'd10);
    queue_req(32'h7FFF_FFFF, 8'd2);
    queue_req(32'h7FFF_FFFF, 8'd10);
    queue_req(32'h7FFF_FFFF, 8'd16);
    queue_req(32'h7FFF_FFFF, 8'd32);
    queue_req(32'h8000_0000, 8'd2);
    queue_req(32'h8000_0000, 8'd10);
    queue_req(32'h8000_0000, 8'd32);
    queue_req(32'h8000_0000, 8'd3);
    queue_req(32'd31, 8'd32);
    queue_req(-32'sd31, 8'd32);
    queue_req(32'd9, 8'd10);
    queue_req(32'd10, 8'd11);
    queue_req(32'd1000, 8'd7);
    queue_req(32'd35, 8'd36);
    queue_req(32'd123, 8'd0);
    queue_req(-32'sd5, 8'd1);
    queue_req(32'd7, 8'd33);
    queue_req(-32'sd7, 8'd255);

    // Hold reset for a few cycles and release it away from the rising edge.
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Eager sender and busy receiver, then the reverse, then full speed.
    run_phase(6, 75, 50);
    run_phase(75, 6, 50);
    run_phase(0, 0, 50);

    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("PASS signed_integer_to_radix_ascii");
    end else begin
      $display("FAIL signed_integer_to_radix_ascii");
    end
    $finish;
  end

endmodule
